// File: rtl/core/fbb_pkg.sv
// Package for the fetch bundle builder: constants, codes and beat types.
`default_nettype none
package fbb_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int CNT_W     = 5;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] BUNDLE_LENGTH_RST = 5'd4;
  localparam logic [CNT_W-1:0] BRANCH_LIMIT_RST  = 5'd2;

  localparam logic CFG_BUNDLE_LENGTH = 1'b0;
  localparam logic CFG_BRANCH_LIMIT  = 1'b1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_INSN  = 1'b1;

  localparam logic [31:0] NOP_WORD = 32'h0000_0013;

  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_COND     = 3'd1,
    KIND_JUMP     = 3'd2,
    KIND_CALL     = 3'd3,
    KIND_RETURN   = 3'd4,
    KIND_CALL_IND = 3'd5,
    KIND_JUMP_IND = 3'd6
  } kind_e;

  typedef struct packed {
    logic             slot_valid;
    logic [63:0]      pc;
    logic [31:0]      insn;
    logic [2:0]       kind;
    logic [63:0]      target;
    logic [63:0]      next_pc;
    logic             fault;
    logic [5:0]       cause;
    logic             last;
    logic             pop;
    logic             push;
    logic [CNT_W-1:0] cond_cnt;
  } beat_t;

  typedef struct packed {
    beat_t            beat;
    logic [CNT_W-1:0] fill;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// File: rtl/core/fbb_front.sv
// Front end: config registers, bundle state, predecode and next pc prediction.
`default_nettype none
module fbb_front
  import fbb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             accept_i,
  input  wire logic             action_i,
  input  wire logic [63:0]      start_pc_i,
  input  wire logic [63:0]      branch_predictions_i,
  input  wire logic [63:0]      indirect_target_i,
  input  wire logic [63:0]      return_target_i,
  input  wire logic [31:0]      insn_word_i,
  input  wire logic             fetch_fault_i,
  input  wire logic [5:0]       fault_cause_i,
  output logic                  push_o,
  output q_entry_t              entry_o
);

  logic [CNT_W-1:0] cfg_len_q, cfg_blim_q;
  logic [63:0]      pc_q, pc_d, pred_q, pred_d, ind_q, ind_d, ret_q, ret_d;
  logic [CNT_W-1:0] pos_q, pos_d, bcnt_q, bcnt_d;
  logic             active_q, active_d;
  logic [1:0]       flags_q, flags_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q  <= BUNDLE_LENGTH_RST;
      cfg_blim_q <= BRANCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUNDLE_LENGTH: cfg_len_q  <= cfg_wdata_i;
        CFG_BRANCH_LIMIT:  cfg_blim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CNT_W-1:0] len;
    logic [31:0]      insn;
    logic [6:0]       opc;
    logic [4:0]       rd, rs1;
    logic [63:0]      b_imm, j_imm, seq_pc, npc, tgt;
    logic [2:0]       kind;
    logic             ends, last;
    logic [CNT_W-1:0] pos_n, bcnt_n;
    logic [1:0]       flags_n;
    logic [63:0]      pred_n;

    if (cfg_len_q == '0) begin
      len = CNT_W'(1);
    end else if (cfg_len_q > CNT_W'(MAX_SLOTS)) begin
      len = CNT_W'(MAX_SLOTS);
    end else begin
      len = cfg_len_q;
    end

    insn   = fetch_fault_i ? NOP_WORD : insn_word_i;
    opc    = insn[6:0];
    rd     = insn[11:7];
    rs1    = insn[19:15];
    b_imm  = {{51{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    j_imm  = {{43{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
    seq_pc = pc_q + 64'd4;
    npc    = seq_pc;
    tgt    = '0;
    kind   = KIND_NONE;
    ends   = fetch_fault_i;
    bcnt_n = bcnt_q;
    flags_n = flags_q;
    pred_n = pred_q;

    case (opc)
      OPC_BRANCH: begin
        kind   = KIND_COND;
        tgt    = pc_q + b_imm;
        npc    = pred_q[1] ? tgt : seq_pc;
        pred_n = {2'b00, pred_q[63:2]};
        bcnt_n = bcnt_q + CNT_W'(1);
        if (bcnt_n == cfg_blim_q) begin
          ends = 1'b1;
        end
      end
      OPC_JAL: begin
        tgt = pc_q + j_imm;
        npc = tgt;
        if (rd == REG_RA) begin
          kind       = KIND_CALL;
          flags_n[1] = 1'b1;
          ends       = 1'b1;
        end else begin
          kind = KIND_JUMP;
        end
      end
      OPC_JALR: begin
        ends = 1'b1;
        if (rd == REG_ZERO && rs1 == REG_RA) begin
          kind       = KIND_RETURN;
          npc        = ret_q;
          flags_n[0] = 1'b1;
        end else if (rd == REG_RA) begin
          kind       = KIND_CALL_IND;
          npc        = ind_q;
          flags_n[1] = 1'b1;
        end else begin
          kind = KIND_JUMP_IND;
          npc  = ind_q;
        end
      end
      default: ;
    endcase

    pos_n = pos_q + CNT_W'(1);
    last  = pos_n >= len;

    entry_o.beat.slot_valid = 1'b1;
    entry_o.beat.pc         = pc_q;
    entry_o.beat.insn       = insn;
    entry_o.beat.kind       = kind;
    entry_o.beat.target     = tgt;
    entry_o.beat.next_pc    = npc;
    entry_o.beat.fault      = fetch_fault_i;
    entry_o.beat.cause      = fetch_fault_i ? fault_cause_i : 6'd0;
    entry_o.beat.last       = last;
    entry_o.beat.pop        = flags_n[0];
    entry_o.beat.push       = flags_n[1];
    entry_o.beat.cond_cnt   = bcnt_n;
    entry_o.fill            = (!last && ends) ? (len - pos_n) : '0;

    push_o   = 1'b0;
    pc_d     = pc_q;
    pred_d   = pred_q;
    ind_d    = ind_q;
    ret_d    = ret_q;
    pos_d    = pos_q;
    bcnt_d   = bcnt_q;
    active_d = active_q;
    flags_d  = flags_q;

    if (accept_i) begin
      if (action_i == ACT_START) begin
        pc_d     = start_pc_i;
        pred_d   = branch_predictions_i;
        ind_d    = indirect_target_i;
        ret_d    = return_target_i;
        pos_d    = '0;
        bcnt_d   = '0;
        flags_d  = '0;
        active_d = 1'b1;
      end else if (active_q) begin
        push_o  = 1'b1;
        pc_d    = npc;
        pred_d  = pred_n;
        bcnt_d  = bcnt_n;
        flags_d = flags_n;
        if (last || ends) begin
          active_d = 1'b0;
          pos_d    = '0;
        end else begin
          pos_d = pos_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      pred_q   <= '0;
      ind_q    <= '0;
      ret_q    <= '0;
      pos_q    <= '0;
      bcnt_q   <= '0;
      active_q <= 1'b0;
      flags_q  <= '0;
    end else begin
      pc_q     <= pc_d;
      pred_q   <= pred_d;
      ind_q    <= ind_d;
      ret_q    <= ret_d;
      pos_q    <= pos_d;
      bcnt_q   <= bcnt_d;
      active_q <= active_d;
      flags_q  <= flags_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fbb_queue.sv
// Small slot queue between the predecode front end and the beat sequencer.
`default_nettype none
module fbb_queue
  import fbb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  q_entry_t      entry_i,
  input  wire logic     pop_i,
  output q_entry_t      head_o,
  output q_status_t     status_o
);

  q_entry_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  assign status_o.full  = cnt_q == QCNT_W'(QDEPTH);
  assign status_o.empty = cnt_q == '0;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: ;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty))
    else $error("queue pop while empty");

endmodule
`default_nettype wire

// File: rtl/core/fbb_back.sv
// Back end: output beat register, emits each real slot then its filler slots.
`default_nettype none
module fbb_back
  import fbb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  q_entry_t      head_i,
  input  q_status_t     q_status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output beat_t         beat_o
);

  logic             vld_q, vld_d;
  beat_t            out_q, out_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             load;

  assign load = !vld_q || !out_stall_i;

  always_comb begin
    vld_d  = vld_q;
    out_d  = out_q;
    fill_d = fill_q;
    pop_o  = 1'b0;
    if (load) begin
      if (fill_q != '0) begin
        // filler keeps next pc, stack flags and branch count of the bundle
        vld_d            = 1'b1;
        out_d.slot_valid = 1'b0;
        out_d.pc         = '0;
        out_d.insn       = '0;
        out_d.kind       = KIND_NONE;
        out_d.target     = '0;
        out_d.fault      = 1'b0;
        out_d.cause      = '0;
        out_d.last       = fill_q == CNT_W'(1);
        fill_d           = fill_q - CNT_W'(1);
      end else if (!q_status_i.empty) begin
        pop_o  = 1'b1;
        vld_d  = 1'b1;
        out_d  = head_i.beat;
        fill_d = head_i.fill;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      fill_q <= '0;
    end else begin
      vld_q  <= vld_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = vld_q;
  assign beat_o      = out_q;

  a_fill_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 |-> vld_q)
    else $error("fillers pending without a beat in the output register");

  a_last_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && out_q.last |-> fill_q == '0)
    else $error("last beat shown while fillers still pending");

  a_filler_after_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !out_q.slot_valid && !out_stall_i && fill_q != '0 |=> !out_q.slot_valid)
    else $error("real slot broke into a filler run");

endmodule
`default_nettype wire

// File: rtl/core/fetch_bundle_builder.sv
// Top level of the fetch bundle builder: front end, slot queue and beat sequencer.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  in       | input     | in_valid_i / in_stall_o | action, start state, insn, fault
//  out      | output    | out_valid_o/out_stall_i | one slot beat, real or filler
//  cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  An input beat is taken every cycle while the four-entry slot queue has room.
//  A real slot passes the slot queue and output register; fillers follow one per
//  cycle while out_stall_i is low; a closed bundle has a beat per configured slot.
//  Reset closes any open bundle and empties the queue and output register.
//  in_stall_o rises only when the queue is full, backed up by out_stall_i or by
//  filler runs that take longer than the instruction beats arriving.
`default_nettype none
module fetch_bundle_builder
  import fbb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             action_i,
  input  wire logic [63:0]      start_pc_i,
  input  wire logic [63:0]      branch_predictions_i,
  input  wire logic [63:0]      indirect_target_i,
  input  wire logic [63:0]      return_target_i,
  input  wire logic [31:0]      insn_word_i,
  input  wire logic             fetch_fault_i,
  input  wire logic [5:0]       fault_cause_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  slot_valid_o,
  output logic [63:0]           slot_pc_o,
  output logic [31:0]           slot_insn_o,
  output logic [2:0]            branch_kind_o,
  output logic [63:0]           slot_target_o,
  output logic [63:0]           next_pc_o,
  output logic                  fault_o,
  output logic [5:0]            slot_fault_cause_o,
  output logic                  last_slot_o,
  output logic                  pop_stack_o,
  output logic                  push_stack_o,
  output logic [CNT_W-1:0]      cond_branch_count_o
);

  logic      accept, push, pop;
  q_entry_t  entry, head;
  q_status_t q_status;
  beat_t     beat;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  fbb_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .accept_i             (accept),
    .action_i,
    .start_pc_i,
    .branch_predictions_i,
    .indirect_target_i,
    .return_target_i,
    .insn_word_i,
    .fetch_fault_i,
    .fault_cause_i,
    .push_o               (push),
    .entry_o              (entry)
  );

  fbb_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  fbb_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .beat_o      (beat)
  );

  assign slot_valid_o        = beat.slot_valid;
  assign slot_pc_o           = beat.pc;
  assign slot_insn_o         = beat.insn;
  assign branch_kind_o       = beat.kind;
  assign slot_target_o       = beat.target;
  assign next_pc_o           = beat.next_pc;
  assign fault_o             = beat.fault;
  assign slot_fault_cause_o  = beat.cause;
  assign last_slot_o         = beat.last;
  assign pop_stack_o         = beat.pop;
  assign push_stack_o        = beat.push;
  assign cond_branch_count_o = beat.cond_cnt;

endmodule
`default_nettype wire

// File: test/tb_fetch_bundle_builder.sv
// Testbench for fetch_bundle_builder: random and directed bundles against a slot predictor.
`timescale 1ns / 1ps
module tb_fetch_bundle_builder
  import fbb_pkg::*;
;

  localparam int MAX_GAP        = 12;
  localparam int LONG_HOLD      = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_SET  = 30;
  localparam int NUM_SETS       = 9;

  class slot_scoreboard;
    beat_t      expected_q[$];
    int         errors;
    logic [4:0] bundle_length;
    logic [4:0] branch_limit;
    logic [63:0] cur_pc;
    logic [63:0] pred_bits;
    logic [63:0] ind_target;
    logic [63:0] ret_target;
    logic [4:0] slot_pos;
    logic [4:0] br_count;
    logic       active;
    logic       pop_flag;
    logic       push_flag;

    function new();
      errors        = 0;
      bundle_length = BUNDLE_LENGTH_RST;
      branch_limit  = BRANCH_LIMIT_RST;
      cur_pc        = '0;
      pred_bits     = '0;
      ind_target    = '0;
      ret_target    = '0;
      slot_pos      = '0;
      br_count      = '0;
      active        = 1'b0;
      pop_flag      = 1'b0;
      push_flag     = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_config(logic idx, logic [4:0] value);
      if (idx == CFG_BUNDLE_LENGTH) begin
        bundle_length = value;
      end else begin
        branch_limit = value;
      end
    endfunction

    // Work out the slots that one accepted input beat produces.
    function void note_beat(logic act, logic [63:0] spc, logic [63:0] preds,
                            logic [63:0] itgt, logic [63:0] rtgt, logic [31:0] word,
                            logic flt, logic [5:0] cause);
      logic [4:0]  eff_len;
      logic [63:0] pc;
      logic [63:0] npc;
      logic [63:0] tgt;
      logic [63:0] imm;
      logic [31:0] insn;
      logic [6:0]  opc;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic        ends;
      logic        taken;
      logic        last;
      kind_e       kind;
      if (act == ACT_START) begin
        cur_pc     = spc;
        pred_bits  = preds;
        ind_target = itgt;
        ret_target = rtgt;
        slot_pos   = '0;
        br_count   = '0;
        pop_flag   = 1'b0;
        push_flag  = 1'b0;
        active     = 1'b1;
        return;
      end
      if (!active) return;
      if (bundle_length == 0) eff_len = 5'd1;
      else if (bundle_length > MAX_SLOTS) eff_len = 5'(MAX_SLOTS);
      else eff_len = bundle_length;
      pc   = cur_pc;
      insn = flt ? NOP_WORD : word;
      ends = flt;
      npc  = pc + 64'd4;
      tgt  = '0;
      kind = KIND_NONE;
      opc  = insn[6:0];
      rd   = insn[11:7];
      rs1  = insn[19:15];
      case (opc)
        OPC_BRANCH: begin
          imm       = {{51{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
          taken     = pred_bits[1];
          pred_bits = pred_bits >> 2;
          br_count  = br_count + 5'd1;
          kind      = KIND_COND;
          tgt       = pc + imm;
          npc       = taken ? tgt : pc + 64'd4;
          if (br_count == branch_limit) ends = 1'b1;
        end
        OPC_JAL: begin
          imm = {{43{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
          tgt = pc + imm;
          npc = tgt;
          if (rd == REG_RA) begin
            kind      = KIND_CALL;
            push_flag = 1'b1;
            ends      = 1'b1;
          end else begin
            kind = KIND_JUMP;
          end
        end
        OPC_JALR: begin
          if (rd == REG_ZERO && rs1 == REG_RA) begin
            kind     = KIND_RETURN;
            npc      = ret_target;
            pop_flag = 1'b1;
          end else if (rd == REG_RA) begin
            kind      = KIND_CALL_IND;
            npc       = ind_target;
            push_flag = 1'b1;
          end else begin
            kind = KIND_JUMP_IND;
            npc  = ind_target;
          end
          ends = 1'b1;
        end
        default: ;
      endcase
      slot_pos = slot_pos + 5'd1;
      cur_pc   = npc;
      last     = slot_pos >= eff_len;
      expected_q.push_back('{slot_valid: 1'b1, pc: pc, insn: insn, kind: kind, target: tgt,
                             next_pc: npc, fault: flt, cause: flt ? cause : 6'd0,
                             last: last, pop: pop_flag, push: push_flag,
                             cond_cnt: br_count});
      if (last || ends) begin
        active = 1'b0;
        while (slot_pos < eff_len) begin
          slot_pos = slot_pos + 5'd1;
          expected_q.push_back('{slot_valid: 1'b0, pc: '0, insn: '0, kind: KIND_NONE,
                                 target: '0, next_pc: npc, fault: 1'b0, cause: '0,
                                 last: slot_pos >= eff_len, pop: pop_flag,
                                 push: push_flag, cond_cnt: br_count});
        end
        slot_pos = '0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_slot(beat_t got);
      beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected slot beat, expected none actual pc %0h", $time, got.pc);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("slot_valid", 64'(want.slot_valid), 64'(got.slot_valid));
      compare_field("slot_pc", want.pc, got.pc);
      compare_field("slot_insn", 64'(want.insn), 64'(got.insn));
      compare_field("branch_kind", 64'(want.kind), 64'(got.kind));
      compare_field("slot_target", want.target, got.target);
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("fault", 64'(want.fault), 64'(got.fault));
      compare_field("slot_fault_cause", 64'(want.cause), 64'(got.cause));
      compare_field("last_slot", 64'(want.last), 64'(got.last));
      compare_field("pop_stack", 64'(want.pop), 64'(got.pop));
      compare_field("push_stack", 64'(want.push), 64'(got.push));
      compare_field("cond_branch_count", 64'(want.cond_cnt), 64'(got.cond_cnt));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             action_i;
  logic [63:0]      start_pc_i;
  logic [63:0]      branch_predictions_i;
  logic [63:0]      indirect_target_i;
  logic [63:0]      return_target_i;
  logic [31:0]      insn_word_i;
  logic             fetch_fault_i;
  logic [5:0]       fault_cause_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             slot_valid_o;
  logic [63:0]      slot_pc_o;
  logic [31:0]      slot_insn_o;
  logic [2:0]       branch_kind_o;
  logic [63:0]      slot_target_o;
  logic [63:0]      next_pc_o;
  logic             fault_o;
  logic [5:0]       slot_fault_cause_o;
  logic             last_slot_o;
  logic             pop_stack_o;
  logic             push_stack_o;
  logic [CNT_W-1:0] cond_branch_count_o;

  slot_scoreboard sb;
  int             beats_seen = 0;
  bit             send_idle = 1'b1;
  bit             recv_idle = 1'b1;
  bit             long_hold_req = 1'b0;

  fetch_bundle_builder i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] enc_branch(logic [12:0] imm);
    return {imm[12], imm[10:5], 5'd9, 5'd8, 3'b001, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_jalr(logic [4:0] rd, logic [4:0] rs1);
    return {12'h7f8, rs1, 3'b000, rd, OPC_JALR};
  endfunction

  function automatic logic [31:0] random_insn();
    logic [31:0] w;
    int          pick;
    w    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
    end else if (pick < 60) begin
      w[6:0] = OPC_BRANCH;
    end else if (pick < 70) begin
      w[6:0] = OPC_JAL;
    end else if (pick < 76) begin
      w[6:0]  = OPC_JAL;
      w[11:7] = REG_RA;
    end else if (pick < 84) begin
      w[6:0]   = OPC_JALR;
      w[11:7]  = REG_ZERO;
      w[19:15] = REG_RA;
    end else if (pick < 92) begin
      w[6:0]  = OPC_JALR;
      w[11:7] = REG_RA;
    end else begin
      w[6:0] = OPC_JALR;
    end
    return w;
  endfunction

  task automatic send_beat(logic act, logic [63:0] spc, logic [63:0] preds,
                           logic [63:0] itgt, logic [63:0] rtgt, logic [31:0] word,
                           logic flt, logic [5:0] cause);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if ($urandom_range(0, 29) == 0) send_idle = !send_idle;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    action_i             <= act;
    start_pc_i           <= spc;
    branch_predictions_i <= preds;
    indirect_target_i    <= itgt;
    return_target_i      <= rtgt;
    insn_word_i          <= word;
    fetch_fault_i        <= flt;
    fault_cause_i        <= cause;
    do @(posedge clk_i); while (in_stall_o);
    beats_seen++;
    sb.note_beat(act, spc, preds, itgt, rtgt, word, flt, cause);
  endtask

  task automatic send_start(logic [63:0] spc, logic [63:0] preds, logic [63:0] itgt,
                            logic [63:0] rtgt);
    send_beat(ACT_START, spc, preds, itgt, rtgt, $urandom, 1'b0, '0);
  endtask

  task automatic send_insn(logic [31:0] word, logic flt, logic [5:0] cause);
    send_beat(ACT_INSN, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, word, flt, cause);
  endtask

  task automatic apply_config(logic [4:0] len, logic [4:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BUNDLE_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BRANCH_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(CFG_BUNDLE_LENGTH, len);
    sb.set_config(CFG_BRANCH_LIMIT, limit);
  endtask

  // Close any open bundle with a faulted fetch, then wait for the block to go quiet.
  task automatic end_phase();
    if (sb.active) send_insn(NOP_WORD, 1'b1, 6'($urandom_range(0, 63)));
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_insn(32'h0000_0013, 1'b0, 6'd0);
    send_start(64'hFFFF_FFFF_FFFF_FFF8, 64'hFFFF_FFFF_FFFF_FFF7, 64'h0,
               64'hFFFF_FFFF_FFFF_FFFF);
    send_insn(32'hFFFF_FFFF, 1'b0, 6'd0);
    send_insn(enc_branch(13'h0FFE), 1'b0, 6'd0);
    send_insn(enc_branch(13'h1000), 1'b0, 6'd0);
    send_start(64'h0, 64'h2, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0);
    send_insn(enc_jal(5'd0, 21'h10_0000), 1'b0, 6'd0);
    send_insn(enc_branch(13'h0010), 1'b0, 6'd0);
    send_insn(enc_jal(REG_RA, 21'h0F_FFFE), 1'b0, 6'd0);
    send_start(64'h8000_0000_0000_0000, 64'h0, 64'h0000_1234_5678_9ABC,
               64'hFFFF_FFFF_FFFF_FFFC);
    send_insn(enc_jalr(REG_ZERO, REG_RA), 1'b0, 6'd0);
    send_start(64'h7FFF_FFFF_FFFF_FFFC, 64'h0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h40);
    send_insn(enc_jalr(REG_RA, 5'd7), 1'b0, 6'd0);
    send_start(64'h1000, 64'h0, 64'h2000, 64'h3000);
    send_insn(enc_jalr(5'd31, REG_RA), 1'b0, 6'd0);
    send_start(64'h4000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
    send_insn(enc_branch(13'h0FFE), 1'b1, 6'h3F);
    send_start(64'h5000, 64'h0, 64'h0, 64'h0);
    send_insn(32'h0000_0033, 1'b0, 6'd0);
    send_insn(32'h0000_0000, 1'b0, 6'd0);
    send_start(64'h6000, 64'h0, 64'h0, 64'h0);
    send_insn(32'h0000_0013, 1'b0, 6'd0);
    send_insn(32'h0010_0093, 1'b0, 6'd0);
    send_insn(32'hFFFF_FF93, 1'b0, 6'd0);
    send_insn(32'h0000_0013, 1'b0, 6'd0);
  endtask

  // Mostly complete bundles with random content; a few abandoned ones and stray fetches.
  task automatic run_random(int n);
    int          done;
    int          abandon_at;
    int          k;
    logic [63:0] spc;
    done = 0;
    while (done < n) begin
      if (!sb.active && $urandom_range(0, 19) == 0) begin
        send_insn(random_insn(), 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end
      spc = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) spc = 64'hFFFF_FFFF_FFFF_FFC0 | 64'($urandom_range(0, 63));
      send_beat(ACT_START, spc, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)),
                6'($urandom_range(0, 63)));
      done++;
      abandon_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
      k = 0;
      while (sb.active && k != abandon_at) begin
        send_insn(random_insn(), $urandom_range(0, 15) == 0, 6'($urandom_range(0, 63)));
        done++;
        k++;
      end
    end
  endtask

  initial begin : receiver
    int    hold_left;
    beat_t got;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{slot_valid: slot_valid_o, pc: slot_pc_o, insn: slot_insn_o,
                kind: branch_kind_o, target: slot_target_o, next_pc: next_pc_o,
                fault: fault_o, cause: slot_fault_cause_o, last: last_slot_o,
                pop: pop_stack_o, push: push_stack_o, cond_cnt: cond_branch_count_o};
        sb.check_slot(got);
        beats_seen++;
        hold_left = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
        if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
      end
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      out_stall_i <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin : watchdog
    int quiet;
    int last_seen;
    quiet     = 0;
    last_seen = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (beats_seen != last_seen) begin
        last_seen = beats_seen;
        quiet     = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_fetch_bundle_builder failed");
    $finish;
  end

  initial begin : stimulus
    int lens[NUM_SETS];
    int limits[NUM_SETS];
    sb = new();
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_BUNDLE_LENGTH;
    cfg_wdata_i          <= '0;
    in_valid_i           <= 1'b0;
    action_i             <= ACT_START;
    start_pc_i           <= '0;
    branch_predictions_i <= '0;
    indirect_target_i    <= '0;
    return_target_i      <= '0;
    insn_word_i          <= '0;
    fetch_fault_i        <= 1'b0;
    fault_cause_i        <= '0;
    lens   = '{1, 16, 0, 31, 8, 16, 2, 4, 4};
    limits = '{1, 16, 0, 31, 3, 1, 0, 2, 2};
    lens[7]   = $urandom_range(1, 16);
    limits[7] = $urandom_range(1, 16);
    lens[8]   = $urandom_range(1, 16);
    limits[8] = $urandom_range(0, 31);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    end_phase();
    for (int s = 0; s < NUM_SETS; s++) begin
      apply_config(5'(lens[s]), 5'(limits[s]));
      // Back up the output side while input keeps coming.
      if (s == 1) long_hold_req = 1'b1;
      run_random(ITEMS_PER_SET);
      end_phase();
    end
    if (sb.errors == 0) begin
      $display("tb_fetch_bundle_builder passed");
    end else begin
      $display("tb_fetch_bundle_builder failed");
    end
    $finish;
  end

endmodule
